// ----- rtl/core/swh_pkg.sv -----
// ----------------------------------------------------------------------------
// swh_pkg
// Shared constants, types and helpers of the streaming wyhash-style hasher.
// ----------------------------------------------------------------------------
package swh_pkg;

  localparam logic [63:0] SecretA    = 64'ha0761d6478bd642f;
  localparam logic [63:0] SecretB    = 64'he7037ed1a0b428db;
  localparam int unsigned BlockBytes = 16;
  localparam int unsigned CountW     = $clog2(BlockBytes) + 1;
  localparam int unsigned IdxW       = $clog2(BlockBytes);

  // fold of a full 128-bit product, only evaluated on constants
  function automatic logic [63:0] mix_fold_const(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return p[63:0] ^ p[127:64];
  endfunction

  localparam logic [63:0] SeedInit = mix_fold_const(SecretA, SecretB);

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FOLD = 4'b0010,
    ST_FIN1 = 4'b0100,
    ST_FIN2 = 4'b1000
  } state_e;

  // request to the shared multiplier
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  // request to the hold buffer
  typedef struct packed {
    logic       wr;
    logic       clr;
    logic [7:0] data;
  } hold_req_t;

endpackage

// ----- rtl/core/streaming_wyhash64_top.sv -----
// ----------------------------------------------------------------------------
// streaming_wyhash64_top
// Byte-serial wyhash-style 64-bit hash with zero seed, built around one
// shared iterative 64x64->128 multiplier under a small sequencer.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------
//   in      | input     | in_valid_i / in_ready_o  | kind_i, data_byte_i
//   out     | output    | out_valid_o / out_ready_i| hash_value_o
//
// A data byte that arrives while the hold buffer is already full starts a fold,
// and the input is busy for the 4 partial products, a final accumulate and the
// seed update.
// A finish runs two dependent multiplies; its result is held back while a previous
// result still waits in the output register.
// All products come from the one shared multiplier.
// Reset loads the initial seed and clears counts; no clearing pass.
// The result sits in an output register; data bytes are taken while it waits.
// ----------------------------------------------------------------------------
module streaming_wyhash64_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o
);
  import swh_pkg::*;

  state_e      state_q, state_d;
  logic [63:0] seed_q, seed_d;
  logic [63:0] total_q, total_d;
  logic [63:0] hash_q;
  logic        out_valid_q;

  mul_req_t    mul_req;
  hold_req_t   hold_req;
  logic        mul_busy;
  logic [63:0] mul_lo, mul_hi;
  logic        hold_full;
  logic [63:0] lo_word, hi_word, tail_a, tail_b;
  logic        in_accept;
  logic        fin_done;

  swh_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .busy_o (mul_busy),
    .lo_o   (mul_lo),
    .hi_o   (mul_hi)
  );

  swh_hold u_hold (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (hold_req),
    .full_o    (hold_full),
    .lo_word_o (lo_word),
    .hi_word_o (hi_word),
    .tail_a_o  (tail_a),
    .tail_b_o  (tail_b)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign fin_done   = (state_q == ST_FIN2) && !mul_busy && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d       = state_q;
    seed_d        = seed_q;
    total_d       = total_q;
    mul_req       = '0;
    hold_req      = '0;
    hold_req.data = data_byte_i;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (!kind_i) begin
            total_d     = total_q + 64'd1;
            hold_req.wr = 1'b1;
            if (hold_full) begin
              mul_req = '{start: 1'b1, a: lo_word ^ SecretB, b: hi_word ^ seed_q};
              state_d = ST_FOLD;
            end
          end else begin
            mul_req = '{start: 1'b1, a: tail_a ^ SecretB, b: tail_b ^ seed_q};
            state_d = ST_FIN1;
          end
        end
      end
      ST_FOLD: begin
        if (!mul_busy) begin
          seed_d  = mul_lo ^ mul_hi;
          state_d = ST_IDLE;
        end
      end
      ST_FIN1: begin
        if (!mul_busy) begin
          mul_req = '{start: 1'b1, a: mul_lo ^ SecretA ^ total_q, b: mul_hi ^ SecretB};
          state_d = ST_FIN2;
        end
      end
      ST_FIN2: begin
        if (fin_done) begin
          seed_d       = SeedInit;
          total_d      = '0;
          hold_req.clr = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= SeedInit;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      seed_q  <= seed_d;
      total_q <= total_d;
      if (fin_done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (fin_done) begin
      hash_q <= mul_lo ^ mul_hi;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

  // checks
  a_ready_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !mul_busy) else $error("input open while multiplier busy");
  a_fold_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FOLD && !mul_busy) |=> state_q == ST_IDLE)
    else $error("fold did not return to idle");
  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN2 && out_valid_q && !out_ready_i) |=> state_q == ST_FIN2)
    else $error("finish overwrote a pending result");
  a_fin_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_done |=> total_q == 64'd0 && seed_q == SeedInit && out_valid_q)
    else $error("finish did not restart the message");

endmodule

// ----- rtl/core/swh_mul.sv -----
// ----------------------------------------------------------------------------
// swh_mul
// Iterative 64x64->128 multiplier: one 32x32 partial product per cycle,
// registered, then accumulated into a 128-bit sum.
// ----------------------------------------------------------------------------
module swh_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swh_pkg::mul_req_t req_i,
  output logic              busy_o,
  output logic [63:0]       lo_o,
  output logic [63:0]       hi_o
);
  import swh_pkg::*;

  logic [63:0]  a_q, b_q;
  logic [2:0]   step_q;
  logic         busy_q;
  logic         pp_vld_q;
  logic [1:0]   sh_q;
  logic [63:0]  pp_q;
  logic [127:0] acc_q;

  logic [31:0]  op_x, op_y;
  logic [1:0]   sh_d;
  logic [127:0] pp_shifted;

  // operand halves and weight per step
  always_comb begin
    case (step_q[1:0])
      2'd0: begin
        op_x = a_q[31:0];  op_y = b_q[31:0];  sh_d = 2'd0;
      end
      2'd1: begin
        op_x = a_q[31:0];  op_y = b_q[63:32]; sh_d = 2'd1;
      end
      2'd2: begin
        op_x = a_q[63:32]; op_y = b_q[31:0];  sh_d = 2'd1;
      end
      default: begin
        op_x = a_q[63:32]; op_y = b_q[63:32]; sh_d = 2'd2;
      end
    endcase
  end

  // align the registered partial product
  always_comb begin
    case (sh_q)
      2'd0:    pp_shifted = {64'd0, pp_q};
      2'd1:    pp_shifted = {32'd0, pp_q, 32'd0};
      default: pp_shifted = {pp_q, 64'd0};
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      step_q   <= '0;
      pp_vld_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q   <= 1'b1;
      step_q   <= '0;
      pp_vld_q <= 1'b0;
    end else if (busy_q) begin
      if (step_q != 3'd4) begin
        step_q   <= step_q + 3'd1;
        pp_vld_q <= 1'b1;
      end else begin
        pp_vld_q <= 1'b0;
        if (pp_vld_q) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q != 3'd4) begin
        pp_q <= {32'd0, op_x} * {32'd0, op_y};
        sh_q <= sh_d;
      end
      if (pp_vld_q) begin
        acc_q <= acc_q + pp_shifted;
      end
    end
  end

  assign busy_o = busy_q;
  assign lo_o   = acc_q[63:0];
  assign hi_o   = acc_q[127:64];

  // checks
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("multiplier started while busy");
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q && step_q == 3'd0) else $error("multiplier did not start");
  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> step_q == 3'd4 && !pp_vld_q) else $error("multiplier ended early");

endmodule

// ----- rtl/core/swh_hold.sv -----
// ----------------------------------------------------------------------------
// swh_hold
// 16-byte hold buffer with fill count; gives the fold words of a full block
// and the two tail words read the wyhash way.
// ----------------------------------------------------------------------------
module swh_hold (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swh_pkg::hold_req_t req_i,
  output logic               full_o,
  output logic [63:0]        lo_word_o,
  output logic [63:0]        hi_word_o,
  output logic [63:0]        tail_a_o,
  output logic [63:0]        tail_b_o
);
  import swh_pkg::*;

  localparam int unsigned BufW = 8 * BlockBytes;

  logic [CountW-1:0] count_q;
  logic [BufW-1:0]   buf_q;
  logic [IdxW-1:0]   wr_idx;

  logic [CountW-1:0] off, pos_b_hi, pos_b_lo;

  function automatic logic [31:0] get32(input logic [BufW-1:0] v, input logic [IdxW-1:0] p);
    logic [BufW-1:0] s;
    s = v >> {p, 3'b000};
    return s[31:0];
  endfunction

  function automatic logic [7:0] get8(input logic [BufW-1:0] v, input logic [IdxW-1:0] p);
    logic [BufW-1:0] s;
    s = v >> {p, 3'b000};
    return s[7:0];
  endfunction

  assign full_o = (count_q >= CountW'(BlockBytes));
  // a full buffer restarts at the first byte
  assign wr_idx = full_o ? '0 : count_q[IdxW-1:0];

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (req_i.clr) begin
      count_q <= '0;
    end else if (req_i.wr) begin
      count_q <= full_o ? CountW'(1) : count_q + CountW'(1);
    end
  end

  // byte lanes
  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      buf_q[{wr_idx, 3'b000} +: 8] <= req_i.data;
    end
  end

  assign lo_word_o = buf_q[63:0];
  assign hi_word_o = buf_q[127:64];

  // tail positions for lengths 4..16
  assign off      = CountW'({count_q[CountW-1:3], 2'b00});
  assign pos_b_hi = count_q - CountW'(4);
  assign pos_b_lo = count_q - CountW'(4) - off;

  // tail read by length class
  always_comb begin
    if (count_q >= CountW'(4)) begin
      tail_a_o = {get32(buf_q, '0), get32(buf_q, off[IdxW-1:0])};
      tail_b_o = {get32(buf_q, pos_b_hi[IdxW-1:0]), get32(buf_q, pos_b_lo[IdxW-1:0])};
    end else if (count_q != '0) begin
      tail_a_o = {40'd0, get8(buf_q, '0), get8(buf_q, count_q[IdxW:1]),
                  get8(buf_q, count_q[IdxW-1:0] - IdxW'(1))};
      tail_b_o = '0;
    end else begin
      tail_a_o = '0;
      tail_b_o = '0;
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(BlockBytes)) else $error("hold count beyond block size");
  a_wrap_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.wr && !req_i.clr && full_o) |=> count_q == CountW'(1))
    else $error("full buffer did not restart");

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming wyhash-style hasher. A directed
// table covers the tail-read cases, then random messages of mixed lengths run
// under four idle/stall phases. Every hash is checked against a predictor
// in the bench that tracks seed, byte count and hold buffer.
// ----------------------------------------------------------------------------
module tb;
  import swh_pkg::*;

  // item kinds on the input channel
  localparam logic KindData   = 1'b0;
  localparam logic KindFinish = 1'b1;

  localparam int unsigned ItemTarget  = 1750;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned DirRows     = 25;

  // directed rows: {kind, data byte}
  localparam logic [8:0] DirectedRows [DirRows] = '{
    // empty message, then a finish carrying a byte that must be ignored
    {KindFinish, 8'h00}, {KindFinish, 8'hff},
    // single byte
    {KindData, 8'hff}, {KindFinish, 8'h00},
    // three bytes
    {KindData, 8'h00}, {KindData, 8'hff}, {KindData, 8'h5a}, {KindFinish, 8'h00},
    // one full block held as the tail, walking ones and zeros
    {KindData, 8'h01}, {KindData, 8'h02}, {KindData, 8'h04}, {KindData, 8'h08},
    {KindData, 8'h10}, {KindData, 8'h20}, {KindData, 8'h40}, {KindData, 8'h80},
    {KindData, 8'hfe}, {KindData, 8'hfd}, {KindData, 8'hfb}, {KindData, 8'hf7},
    {KindData, 8'hef}, {KindData, 8'hdf}, {KindData, 8'hbf}, {KindData, 8'h7f},
    {KindFinish, 8'h00}
  };

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic        kind_i       = 1'b0;
  logic [7:0]  data_byte_i  = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [63:0] hash_value_o;

  // predictor state
  logic [63:0] hash_seed;
  logic [63:0] byte_count;
  logic [7:0]  held_block [BlockBytes];
  int unsigned held_n;

  logic [63:0] digest_q [$];
  int unsigned fail_count     = 0;
  int unsigned hashes_checked = 0;
  int unsigned items_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  streaming_wyhash64_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // 64x64 product folded by xor of its halves
  function automatic logic [63:0] fold_product(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return p[63:0] ^ p[127:64];
  endfunction

  // little-endian read of n held bytes, index wraps at the block size
  function automatic logic [63:0] held_le(input int unsigned pos, input int unsigned n);
    logic [63:0] v;
    int unsigned i;
    v = '0;
    for (i = 0; i < n; i++) begin
      v |= 64'(held_block[(pos + i) % BlockBytes]) << (8 * i);
    end
    return v;
  endfunction

  // tail read plus the two dependent mixes with the length
  function automatic logic [63:0] tail_digest();
    int unsigned n;
    int unsigned off;
    logic [63:0] a;
    logic [63:0] b;
    logic [127:0] p;
    n = (held_n > BlockBytes) ? BlockBytes : held_n;
    if (n >= 4) begin
      off = (n >> 3) << 2;
      a = (held_le(0, 4) << 32) | held_le(off, 4);
      b = (held_le(n - 4, 4) << 32) | held_le(n - 4 - off, 4);
    end else if (n != 0) begin
      a = {40'd0, held_block[0], held_block[n >> 1], held_block[n - 1]};
      b = '0;
    end else begin
      a = '0;
      b = '0;
    end
    a ^= SecretB;
    b ^= hash_seed;
    p = {64'd0, a} * {64'd0, b};
    return fold_product(p[63:0] ^ SecretA ^ byte_count, p[127:64] ^ SecretB);
  endfunction

  function automatic void restart_message();
    hash_seed  = fold_product(SecretA, SecretB);
    byte_count = '0;
    held_n     = 0;
  endfunction

  // result check first, then predict on the accepted input transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_message();
    end else begin
      if (out_valid_o && out_ready_i) begin
        hashes_checked++;
        if (digest_q.size() == 0) begin
          if (fail_count < MaxReports) begin
            $display("unexpected hash %h with nothing pending", hash_value_o);
          end
          fail_count++;
        end else if (digest_q[0] !== hash_value_o) begin
          if (fail_count < MaxReports) begin
            $display("hash mismatch: expected %h actual %h", digest_q[0], hash_value_o);
          end
          fail_count++;
          void'(digest_q.pop_front());
        end else begin
          void'(digest_q.pop_front());
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (kind_i == KindData) begin
          byte_count += 64'd1;
          if (held_n >= BlockBytes) begin
            hash_seed = fold_product(held_le(0, 8) ^ SecretB, held_le(8, 8) ^ hash_seed);
            held_n    = 0;
          end
          held_block[held_n % BlockBytes] = data_byte_i;
          held_n++;
        end else begin
          digest_q.push_back(tail_digest());
          restart_message();
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // one input transaction; valid stays high afterwards unless a gap follows
  task automatic push_item(input logic kind, input logic [7:0] data);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    data_byte_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // sender holds off until every pending hash has arrived
  task automatic drain_hashes();
    in_valid_i <= 1'b0;
    // let the predictor record the last accepted transaction first
    @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  // random message, lengths weighted toward block boundaries and short tails
  task automatic send_message();
    int unsigned sel;
    int unsigned len;
    int unsigned i;
    sel = $urandom_range(99);
    if (sel < 12) begin
      len = $urandom_range(3);
    end else if (sel < 22) begin
      case ($urandom_range(6))
        0: len = 15;
        1: len = 16;
        2: len = 17;
        3: len = 31;
        4: len = 32;
        5: len = 33;
        default: len = 48;
      endcase
    end else if (sel < 62) begin
      len = $urandom_range(20, 4);
    end else if (sel < 90) begin
      len = $urandom_range(64, 21);
    end else begin
      len = $urandom_range(200, 65);
    end
    for (i = 0; i < len; i++) begin
      push_item(KindData, 8'($urandom_range(255)));
    end
    push_item(KindFinish, 8'($urandom_range(255)));
  endtask

  // stimulus
  initial begin
    int unsigned i;
    int unsigned phase;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (i = 0; i < DirRows; i++) begin
      push_item(DirectedRows[i][8], DirectedRows[i][7:0]);
    end
    drain_hashes();

    // random phases: none, sender idle, receiver stall, both
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      while (items_sent < DirRows + (phase + 1) * ItemTarget / 4) send_message();
      drain_hashes();
    end

    // let any late output show up
    repeat (40) @(posedge clk_i);
    if (digest_q.size() != 0) begin
      $display("%0d expected hashes never arrived", digest_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
